### hdl/slc_pkg.sv
// Shared types and constants of the three-phase sine table commutator.
package slc_pkg;

  // Input mode codes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ABS  = 2'd1;
  localparam logic [1:0] MODE_REL  = 2'd2;

  // Drive mode codes (any other value drives the scaled table entry)
  localparam logic [1:0] DRIVE_CENTERED = 2'd1;
  localparam logic [1:0] DRIVE_REVERSED = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PWM_PERIOD = 2'd0;
  localparam logic [1:0] CFG_DRIVE_MODE = 2'd1;

  // Divide by 255 as a multiply: exact for products below 2^24
  localparam int          SCALE_W     = 24;
  localparam int          RECIP_W     = 25;
  localparam int          RECIP_SHIFT = 32;
  localparam logic [24:0] RECIP_255   = 25'd16843010;

  // Results that may be in flight or queued at once
  localparam logic [1:0] CREDIT_MAX = 2'd2;

  // One item as it travels down the index pipeline
  typedef struct packed {
    logic        load;
    logic [1:0]  motor;
    logic [7:0]  power;
    logic [7:0]  tindex;
    logic [15:0] tvalue;
  } slc_item_t;

  // One result word
  typedef struct packed {
    logic [1:0]  motor;
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
  } slc_result_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic       busy;
    logic [1:0] credits;
    logic [1:0] queued;
  } slc_stat_t;

  typedef enum logic [1:0] {
    SEQ_FREE,
    SEQ_B,
    SEQ_C
  } slc_seq_t;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_C
  } slc_phase_t;

endpackage

### hdl/slc_ram.sv
// Generic RAM: one write port, one read port with registered read data.
module slc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read old data on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/slc_front.sv
// Input stage and step counter read-modify-write: yields each item's step.
module slc_front import slc_pkg::*; #(
  parameter int MOTOR_TOTAL    = 3,
  parameter int POSITION_SHIFT = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [1:0]         mode,
  input  logic [1:0]         motor,
  input  logic signed [31:0] position,
  input  logic signed [15:0] step_delta,
  input  logic [7:0]         power,
  input  logic [7:0]         table_index,
  input  logic [15:0]        table_value,
  output logic               b_valid,
  output slc_item_t          b_item,
  output logic signed [31:0] b_step
);

  localparam int MW = (MOTOR_TOTAL > 1) ? $clog2(MOTOR_TOTAL) : 1;

  logic               keep;
  logic               a_valid;
  logic               a_rel;
  slc_item_t          a_item;
  logic signed [31:0] a_pos;
  logic signed [15:0] a_delta;
  logic [MW-1:0]      cnt_raddr;
  logic [31:0]        cnt_rdata;
  logic [31:0]        cnt_cur;
  logic [31:0]        cnt_new;
  logic               cnt_we;
  logic [MOTOR_TOTAL-1:0] cnt_valid;
  logic               fw_valid;
  logic [MW-1:0]      fw_motor;
  logic [31:0]        fw_data;
  logic signed [31:0] step_next;

  // Drop unused modes and motors beyond the count at the door
  assign keep = (mode == MODE_LOAD) ||
                (((mode == MODE_ABS) || (mode == MODE_REL)) && (3'(motor) < 3'(MOTOR_TOTAL)));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rel         <= (mode == MODE_REL);
      a_item.load   <= (mode == MODE_LOAD);
      a_item.motor  <= motor;
      a_item.power  <= power;
      a_item.tindex <= table_index;
      a_item.tvalue <= table_value;
      a_pos         <= position;
      a_delta       <= step_delta;
    end
  end

  // Read the counter of the word in the input stage, re-read while held
  assign cnt_raddr = adv ? motor[MW-1:0] : a_item.motor[MW-1:0];
  assign cnt_we    = adv && a_valid && a_rel;

  slc_ram #(.WIDTH(32), .DEPTH(MOTOR_TOTAL)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (a_item.motor[MW-1:0]),
    .wdata (cnt_new),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Forward last cycle's write; an unwritten counter reads as zero
  always_comb begin
    if (fw_valid && (fw_motor == a_item.motor[MW-1:0])) begin
      cnt_cur = fw_data;
    end else if (cnt_valid[a_item.motor[MW-1:0]]) begin
      cnt_cur = cnt_rdata;
    end else begin
      cnt_cur = '0;
    end
    cnt_new = cnt_cur + {{16{a_delta[15]}}, a_delta};
    if (a_rel) begin
      step_next = $signed(cnt_new);
    end else begin
      step_next = a_pos >>> POSITION_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid  <= 1'b0;
      cnt_valid <= '0;
    end else begin
      fw_valid <= cnt_we;
      if (cnt_we) begin
        cnt_valid[a_item.motor[MW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fw_motor <= a_item.motor[MW-1:0];
    fw_data  <= cnt_new;
  end

  // Advance into the step stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_item <= a_item;
      b_step <= step_next;
    end
  end

endmodule

### hdl/slc_stepmod.sv
// Three-stage reduction of a signed step modulo the table size.
module slc_stepmod import slc_pkg::*; #(
  parameter int TABLE_SIZE = 256,
  localparam int IW = $clog2(TABLE_SIZE)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               b_valid,
  input  slc_item_t          b_item,
  input  logic signed [31:0] b_step,
  output logic               e_valid,
  output slc_item_t          e_item,
  output logic [IW-1:0]      e_rem
);

  // Byte weights 256^k mod N, and the sign weight N - (2^32 mod N)
  localparam int     R1W  = IW + 10;
  localparam int     RCW  = R1W + 2;
  localparam int     PW   = R1W + RCW;
  localparam int     K    = R1W + IW;
  localparam int     QW   = PW - K;
  localparam int     C1   = 256 % TABLE_SIZE;
  localparam int     C2   = 65536 % TABLE_SIZE;
  localparam int     C3   = 16777216 % TABLE_SIZE;
  localparam longint CS   = TABLE_SIZE - (64'h1_0000_0000 % TABLE_SIZE);
  localparam longint RECIP = ((longint'(1) << K) + TABLE_SIZE - 1) / TABLE_SIZE;

  localparam logic [R1W-1:0] C1_W    = R1W'(C1);
  localparam logic [R1W-1:0] C2_W    = R1W'(C2);
  localparam logic [R1W-1:0] C3_W    = R1W'(C3);
  localparam logic [R1W-1:0] CS_W    = R1W'(CS);
  localparam logic [R1W-1:0] N_W     = R1W'(TABLE_SIZE);
  localparam logic [RCW-1:0] RECIP_V = RCW'(RECIP);

  logic            c_valid;
  slc_item_t       c_item;
  logic [R1W-1:0]  c_r1;
  logic [R1W-1:0]  r1_next;
  logic            d_valid;
  slc_item_t       d_item;
  logic [R1W-1:0]  d_r1;
  logic [PW-1:0]   d_prod;
  logic [QW-1:0]   quot;
  logic [R1W-1:0]  qn;
  logic [R1W-1:0]  rem_full;

  // Fold the step into a small value with the same residue
  assign r1_next = R1W'(b_step[7:0]) +
                   R1W'(b_step[15:8]) * C1_W +
                   R1W'(b_step[23:16]) * C2_W +
                   R1W'(b_step[31:24]) * C3_W +
                   (b_step[31] ? CS_W : '0);

  // Quotient by reciprocal, then the exact remainder
  assign quot     = d_prod[PW-1:K];
  assign qn       = R1W'(R1W'(quot) * N_W);
  assign rem_full = d_r1 - qn;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_item <= b_item;
      c_r1   <= r1_next;
      d_item <= c_item;
      d_r1   <= c_r1;
      d_prod <= PW'(c_r1) * PW'(RECIP_V);
      e_item <= d_item;
      e_rem  <= rem_full[IW-1:0];
    end
  end

endmodule

### hdl/slc_phase.sv
// Table sequencer, shared duty pipeline and two-word result queue.
module slc_phase import slc_pkg::*; #(
  parameter int TABLE_SIZE = 256,
  localparam int IW = $clog2(TABLE_SIZE)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          e_valid,
  input  slc_item_t     e_item,
  input  logic [IW-1:0] e_rem,
  input  logic [15:0]   pwm_period,
  input  logic [1:0]    drive_mode,
  input  logic          out_ready,
  output logic          take,
  output logic          out_valid,
  output slc_result_t   result,
  output slc_stat_t     stat
);

  localparam logic [IW:0] N_X   = (IW+1)'(TABLE_SIZE);
  localparam logic [IW:0] OFF_B = (IW+1)'(TABLE_SIZE / 3);
  localparam logic [IW:0] OFF_C = (IW+1)'((2 * TABLE_SIZE) / 3);
  localparam int          MPW   = SCALE_W + RECIP_W;

  slc_seq_t        state, state_next;
  logic [IW-1:0]   seq_rem;
  logic [1:0]      seq_motor;
  logic [7:0]      seq_power;
  logic            issue;
  slc_phase_t      issue_phase;
  logic            credit_ok;
  logic            tbl_we;
  logic [IW-1:0]   tbl_raddr;
  logic [15:0]     tbl_rdata;

  logic            t1_valid;
  slc_phase_t      t1_phase;
  logic [1:0]      t1_motor;
  logic [7:0]      t1_power;
  logic            p1_valid;
  slc_phase_t      p1_phase;
  logic [1:0]      p1_motor;
  logic [SCALE_W-1:0] p1_xe;
  logic [SCALE_W-1:0] p1_xp;
  logic            p2_valid;
  slc_phase_t      p2_phase;
  logic [1:0]      p2_motor;
  logic [15:0]     p2_d;
  logic [15:0]     p2_span;
  logic [MPW-1:0]  me;
  logic [MPW-1:0]  mp;
  logic [15:0]     half;
  logic [16:0]     ctr_sum;
  logic [16:0]     rev_diff;
  logic [15:0]     duty;
  logic [15:0]     col_a;
  logic [15:0]     col_b;

  slc_result_t     q_mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      queued;
  logic [1:0]      credits;
  logic            push;
  logic            pop;

  // Wrap a phase sum back into the table
  function automatic logic [IW-1:0] wrap_idx(input logic [IW:0] s);
    logic [IW:0] w;
    w = (s >= N_X) ? (s - N_X) : s;
    return w[IW-1:0];
  endfunction

  assign pop       = out_valid && out_ready;
  assign credit_ok = (credits < CREDIT_MAX) || pop;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_FREE;
    end else begin
      state <= state_next;
    end
  end

  // Take a word: write a load word to the table, or issue one read per phase
  always_comb begin
    state_next  = state;
    take        = 1'b0;
    issue       = 1'b0;
    issue_phase = PH_A;
    tbl_we      = 1'b0;
    tbl_raddr   = e_rem;
    unique case (state)
      SEQ_FREE: begin
        if (e_valid && (e_item.load || credit_ok)) begin
          take = 1'b1;
          if (e_item.load) begin
            tbl_we = (13'(e_item.tindex) < 13'(TABLE_SIZE));
          end else begin
            issue      = 1'b1;
            state_next = SEQ_B;
          end
        end
      end
      SEQ_B: begin
        issue       = 1'b1;
        issue_phase = PH_B;
        tbl_raddr   = wrap_idx({1'b0, seq_rem} + OFF_B);
        state_next  = SEQ_C;
      end
      SEQ_C: begin
        issue       = 1'b1;
        issue_phase = PH_C;
        tbl_raddr   = wrap_idx({1'b0, seq_rem} + OFF_C);
        state_next  = SEQ_FREE;
      end
      default: begin
        state_next = SEQ_FREE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      seq_rem   <= e_rem;
      seq_motor <= e_item.motor;
      seq_power <= e_item.power;
    end
  end

  slc_ram #(.WIDTH(16), .DEPTH(TABLE_SIZE)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (IW'(e_item.tindex)),
    .wdata (e_item.tvalue),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Duty pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      t1_valid <= issue;
      p1_valid <= t1_valid;
      p2_valid <= p1_valid;
    end
  end

  assign me = MPW'(p1_xe) * MPW'(RECIP_255);
  assign mp = MPW'(p1_xp) * MPW'(RECIP_255);

  // Scale entry and period by power, then divide by 255
  always_ff @(posedge clk) begin
    t1_phase <= issue_phase;
    t1_motor <= (state == SEQ_FREE) ? e_item.motor : seq_motor;
    t1_power <= (state == SEQ_FREE) ? e_item.power : seq_power;
    p1_phase <= t1_phase;
    p1_motor <= t1_motor;
    p1_xe    <= SCALE_W'(tbl_rdata) * SCALE_W'(t1_power);
    p1_xp    <= SCALE_W'(pwm_period) * SCALE_W'(t1_power);
    p2_phase <= p1_phase;
    p2_motor <= p1_motor;
    p2_d     <= me[RECIP_SHIFT +: 16];
    p2_span  <= mp[RECIP_SHIFT +: 16];
  end

  // Shape by drive mode and clamp
  always_comb begin
    half     = 16'(({1'b0, pwm_period} - {1'b0, p2_span}) >> 1);
    ctr_sum  = {1'b0, p2_d} + {1'b0, half};
    rev_diff = {1'b0, pwm_period} - {1'b0, p2_d};
    case (drive_mode)
      DRIVE_CENTERED: duty = ctr_sum[16] ? 16'hFFFF : ctr_sum[15:0];
      DRIVE_REVERSED: duty = rev_diff[16] ? 16'h0000 : rev_diff[15:0];
      default:        duty = p2_d;
    endcase
  end

  // Collect phases A and B, push the word with phase C
  assign push = p2_valid && (p2_phase == PH_C);

  always_ff @(posedge clk) begin
    if (p2_valid && (p2_phase == PH_A)) begin
      col_a <= duty;
    end
    if (p2_valid && (p2_phase == PH_B)) begin
      col_b <= duty;
    end
    if (push) begin
      q_mem[wr_ptr] <= '{motor: p2_motor, duty_a: col_a, duty_b: col_b, duty_c: duty};
    end
  end

  // Result queue pointers and credits for words issued but not delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      queued  <= '0;
      credits <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      queued  <= queued + 2'(push) - 2'(pop);
      credits <= credits + 2'(take && !e_item.load) - 2'(pop);
    end
  end

  assign out_valid    = (queued != '0);
  assign result       = q_mem[rd_ptr];
  assign stat.busy    = (state != SEQ_FREE);
  assign stat.credits = credits;
  assign stat.queued  = queued;

endmodule

### hdl/sine_lut_three_phase_commutator.sv
// Top level of the three-phase sine table commutator.
//
// Input channel (in_valid/in_ready) takes one word per handshake: mode 0
// loads table_value at table_index, mode 1 drives a motor from an absolute
// position shifted right by POSITION_SHIFT, mode 2 adds step_delta to the
// motor's step counter and drives from it. Mode 3 and motors at or above
// MOTOR_TOTAL are accepted and dropped. Each drive word yields one result
// word (motor_out, duty_a, duty_b, duty_c) on the output channel.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set
// pwm_period (index 0) and drive_mode (index 1); cfg_ready is always high.
//
// A drive word holds the sequencer for its three phase reads of the waveform
// table, which has a single read port, and the next word waits until they
// are issued; a load word needs only its table write. While in_ready is
// high, input words are taken back to back into a 5-stage index pipeline.
// A two-word result queue decouples the receiver: while out_ready is low,
// up to two results wait, then in_ready drops and the pipeline holds.
// Reset clears the step counters (through valid bits), the registers and all
// pipeline control; table contents stay undefined until loaded.
module sine_lut_three_phase_commutator import slc_pkg::*; #(
  parameter int TABLE_SIZE     = 256,
  parameter int MOTOR_TOTAL    = 3,
  parameter int POSITION_SHIFT = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [1:0]         motor,
  input  logic signed [31:0] position,
  input  logic signed [15:0] step_delta,
  input  logic [7:0]         power,
  input  logic [7:0]         table_index,
  input  logic [15:0]        table_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         motor_out,
  output logic [15:0]        duty_a,
  output logic [15:0]        duty_b,
  output logic [15:0]        duty_c,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int IW = $clog2(TABLE_SIZE);

  logic               adv;
  logic               b_valid;
  slc_item_t          b_item;
  logic signed [31:0] b_step;
  logic               e_valid;
  slc_item_t          e_item;
  logic [IW-1:0]      e_rem;
  logic               take;
  slc_result_t        result;
  slc_stat_t          stat;
  logic [15:0]        pwm_period;
  logic [1:0]         drive_mode;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= '0;
      drive_mode <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PWM_PERIOD: pwm_period <= cfg_data;
        CFG_DRIVE_MODE: drive_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Hold the whole index pipeline while its last word waits
  assign adv      = !e_valid || take;
  assign in_ready = adv;

  slc_front #(.MOTOR_TOTAL(MOTOR_TOTAL), .POSITION_SHIFT(POSITION_SHIFT)) u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (in_valid),
    .mode        (mode),
    .motor       (motor),
    .position    (position),
    .step_delta  (step_delta),
    .power       (power),
    .table_index (table_index),
    .table_value (table_value),
    .b_valid     (b_valid),
    .b_item      (b_item),
    .b_step      (b_step)
  );

  slc_stepmod #(.TABLE_SIZE(TABLE_SIZE)) u_stepmod (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .b_valid (b_valid),
    .b_item  (b_item),
    .b_step  (b_step),
    .e_valid (e_valid),
    .e_item  (e_item),
    .e_rem   (e_rem)
  );

  slc_phase #(.TABLE_SIZE(TABLE_SIZE)) u_phase (
    .clk        (clk),
    .rst        (rst),
    .e_valid    (e_valid),
    .e_item     (e_item),
    .e_rem      (e_rem),
    .pwm_period (pwm_period),
    .drive_mode (drive_mode),
    .out_ready  (out_ready),
    .take       (take),
    .out_valid  (out_valid),
    .result     (result),
    .stat       (stat)
  );

  assign motor_out = result.motor;
  assign duty_a    = result.duty_a;
  assign duty_b    = result.duty_b;
  assign duty_c    = result.duty_c;

  // Queued words are always covered by credits
  a_queue_in_credit: assert property (@(posedge clk) disable iff (rst)
    stat.queued <= stat.credits)
    else $error("result queue holds more words than issued credits");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    stat.credits <= CREDIT_MAX)
    else $error("credit count above limit");

  // Input stalls only behind a word the sequencer cannot take
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (e_valid && (stat.busy || stat.credits == CREDIT_MAX)))
    else $error("input stalled without a blocked word");

  // A drive word taken keeps the sequencer busy for its phase B and C reads
  a_busy_run: assert property (@(posedge clk) disable iff (rst)
    (take && !e_item.load) |=> stat.busy ##1 stat.busy)
    else $error("phase reads not issued in sequence");

endmodule
